// ===== design/blf_pkg.sv =====
package blf_pkg;

   localparam int unsigned CMD_BITS   = 2;
   localparam int unsigned COLOR_BITS = 32;
   localparam int unsigned COUNT_BITS = 15;
   localparam int unsigned REG_BITS   = 8;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LINE = 2'd0,
      CMD_PLOT = 2'd1,
      CMD_READ = 2'd2,
      CMD_FILL = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_READ_WAIT,
      ST_READ_DATA,
      ST_DONE
   } state_type;

   localparam logic [COUNT_BITS-1:0] COUNT_SAT = {COUNT_BITS{1'b1}};

endpackage

// ===== design/blf_ram.sv =====
module blf_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/blf_front.sv =====
// Front: takes a command beat and parks it in a two-entry queue.
module blf_front #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [blf_pkg::CMD_BITS-1:0]      req_command,
   input  logic signed [COORD_BITS-1:0]      req_x_start,
   input  logic signed [COORD_BITS-1:0]      req_y_start,
   input  logic signed [COORD_BITS-1:0]      req_x_end,
   input  logic signed [COORD_BITS-1:0]      req_y_end,
   input  logic [blf_pkg::COLOR_BITS-1:0]    req_pen_color,
   output logic                              q_valid,
   input  logic                              q_pop,
   output logic [blf_pkg::CMD_BITS-1:0]      q_command,
   output logic signed [COORD_BITS-1:0]      q_x_start,
   output logic signed [COORD_BITS-1:0]      q_y_start,
   output logic signed [COORD_BITS-1:0]      q_x_end,
   output logic signed [COORD_BITS-1:0]      q_y_end,
   output logic [blf_pkg::COLOR_BITS-1:0]    q_pen_color
);

   localparam int unsigned ENTRY_BITS = blf_pkg::CMD_BITS + 4*COORD_BITS
                                        + blf_pkg::COLOR_BITS;

   logic [ENTRY_BITS-1:0] entry_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push_ok;

   assign req_full = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign push_ok  = req_push && !req_full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= {req_command, req_x_start, req_y_start,
                                 req_x_end, req_y_end, req_pen_color};
      end
   end

   assign {q_command, q_x_start, q_y_start, q_x_end, q_y_end, q_pen_color} =
      entry_ff[rd_ptr_ff];

endmodule

// ===== design/blf_back.sv =====
// Back: clears the store after reset, then runs one command at a time,
// one pixel write per cycle.
module blf_back #(
   parameter int unsigned MAX_WIDTH  = 128,
   parameter int unsigned MAX_HEIGHT = 128,
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [blf_pkg::REG_BITS-1:0]      width,
   input  logic [blf_pkg::REG_BITS-1:0]      height,
   output logic                              busy,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  logic [blf_pkg::CMD_BITS-1:0]      q_command,
   input  logic signed [COORD_BITS-1:0]      q_x_start,
   input  logic signed [COORD_BITS-1:0]      q_y_start,
   input  logic signed [COORD_BITS-1:0]      q_x_end,
   input  logic signed [COORD_BITS-1:0]      q_y_end,
   input  logic [blf_pkg::COLOR_BITS-1:0]    q_pen_color,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [blf_pkg::COLOR_BITS-1:0]    rsp_read_color,
   output logic [blf_pkg::COUNT_BITS-1:0]    rsp_pixels_written,
   output logic                              rsp_inside_res
);

   localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned ABITS  = $clog2(DEPTH);
   localparam int unsigned WBITS  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HBITS  = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned EBITS  = COORD_BITS + 4;
   localparam int unsigned PBITS  = WBITS + HBITS;
   localparam int unsigned RBITS  = blf_pkg::REG_BITS;
   localparam int unsigned CB     = blf_pkg::COUNT_BITS;

   typedef logic signed [EBITS-1:0] wide_type;

   blf_pkg::state_type state_ff, state_in;

   // effective width / height, clamped
   logic [WBITS-1:0] eff_w;
   logic [HBITS-1:0] eff_h;
   always_comb begin
      eff_w = (32'(width) > MAX_WIDTH) ? WBITS'(MAX_WIDTH)
            : WBITS'(width);
      eff_h = (32'(height) > MAX_HEIGHT) ? HBITS'(MAX_HEIGHT)
            : HBITS'(height);
   end

   // walk registers
   wide_type x_ff, x_in, y_ff, y_in, e_ff, e_in;
   wide_type two_major_ff, two_major_in, two_minor_ff, two_minor_in;
   logic signed [1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic steep_ff, steep_in;
   logic [EBITS-1:0] left_ff, left_in;
   logic fill_ff, fill_in;
   logic [ABITS:0] fill_k_ff, fill_k_in;
   logic [PBITS-1:0] fill_total_ff, fill_total_in;
   logic [blf_pkg::COLOR_BITS-1:0] color_ff, color_in;
   logic [CB-1:0] n_ff, n_in;
   logic [ABITS-1:0] clr_ff, clr_in;
   logic [blf_pkg::COLOR_BITS-1:0] rd_color_ff, rd_color_in;
   logic ins_ff, ins_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic [blf_pkg::COLOR_BITS-1:0] rsp_color_ff, rsp_color_in;
   logic [CB-1:0] rsp_n_ff, rsp_n_in;
   logic rsp_ins_ff, rsp_ins_in;

   // RAM
   logic wr_en;
   logic [ABITS-1:0] wr_addr, rd_addr_ff, rd_addr_in;
   logic [blf_pkg::COLOR_BITS-1:0] wr_data, rd_data;

   blf_ram #(.WIDTH(blf_pkg::COLOR_BITS), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr_ff),
      .rd_data(rd_data)
   );

   // scissor and address of the current walk pixel (or queue head)
   wide_type px, py;
   logic inside_px;
   logic [ABITS+RBITS:0] lin_addr;
   always_comb begin
      if (state_ff == blf_pkg::ST_WALK) begin
         px = x_ff;
         py = y_ff;
      end else begin
         px = EBITS'(q_x_start);
         py = EBITS'(q_y_start);
      end
      inside_px = (px >= 0) && (py >= 0)
               && (px < $signed({1'b0, EBITS'(eff_w)}))
               && (py < $signed({1'b0, EBITS'(eff_h)}));
      lin_addr = (ABITS+RBITS+1)'(py[HBITS-1:0]) * (ABITS+RBITS+1)'(eff_w)
               + (ABITS+RBITS+1)'(px[WBITS-1:0]);
   end

   // line setup from queue head
   wide_type ddx, ddy, ax, ay, major_v, minor_v;
   always_comb begin
      ddx = EBITS'(q_x_end) - EBITS'(q_x_start);
      ddy = EBITS'(q_y_end) - EBITS'(q_y_start);
      ax  = ddx < 0 ? -ddx : ddx;
      ay  = ddy < 0 ? -ddy : ddy;
      major_v = (ay > ax) ? ay : ax;
      minor_v = (ay > ax) ? ax : ay;
   end

   logic [CB-1:0] n_inc;
   assign n_inc = (n_ff == blf_pkg::COUNT_SAT) ? n_ff : n_ff + CB'(1);

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      e_in          = e_ff;
      two_major_in  = two_major_ff;
      two_minor_in  = two_minor_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      steep_in      = steep_ff;
      left_in       = left_ff;
      fill_in       = fill_ff;
      fill_k_in     = fill_k_ff;
      fill_total_in = fill_total_ff;
      color_in      = color_ff;
      n_in          = n_ff;
      clr_in        = clr_ff;
      rd_color_in   = rd_color_ff;
      ins_in        = ins_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_color_in  = rsp_color_ff;
      rsp_n_in      = rsp_n_ff;
      rsp_ins_in    = rsp_ins_ff;
      rd_addr_in    = rd_addr_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = lin_addr[ABITS-1:0];
      wr_data       = color_ff;

      case (state_ff)
         blf_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ABITS'(1);
            if (clr_ff == ABITS'(DEPTH - 1)) begin
               state_in = blf_pkg::ST_IDLE;
            end
         end
         blf_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               color_in    = q_pen_color;
               n_in        = '0;
               rd_color_in = '0;
               ins_in      = 1'b0;
               case (blf_pkg::cmd_type'(q_command))
                  blf_pkg::CMD_LINE: begin
                     x_in         = EBITS'(q_x_start);
                     y_in         = EBITS'(q_y_start);
                     steep_in     = ay > ax;
                     sx_in        = ddx > 0 ? 2'sd1 : (ddx < 0 ? -2'sd1 : 2'sd0);
                     sy_in        = ddy > 0 ? 2'sd1 : (ddy < 0 ? -2'sd1 : 2'sd0);
                     two_major_in = major_v <<< 1;
                     two_minor_in = minor_v <<< 1;
                     e_in         = (minor_v <<< 1) - major_v;
                     // zero-length line still plots its start point
                     left_in      = (major_v == 0) ? EBITS'(1) : EBITS'(major_v);
                     fill_in      = 1'b0;
                     state_in     = blf_pkg::ST_WALK;
                  end
                  blf_pkg::CMD_PLOT: begin
                     x_in     = EBITS'(q_x_start);
                     y_in     = EBITS'(q_y_start);
                     e_in     = '0;
                     two_major_in = '0;
                     two_minor_in = '0;
                     sx_in    = '0;
                     sy_in    = '0;
                     steep_in = 1'b0;
                     left_in  = EBITS'(1);
                     fill_in  = 1'b0;
                     ins_in   = inside_px;
                     state_in = blf_pkg::ST_WALK;
                  end
                  blf_pkg::CMD_READ: begin
                     ins_in     = inside_px;
                     rd_addr_in = lin_addr[ABITS-1:0];
                     state_in   = blf_pkg::ST_READ_WAIT;
                  end
                  default: begin
                     fill_in       = 1'b1;
                     fill_k_in     = '0;
                     fill_total_in = PBITS'(eff_w) * PBITS'(eff_h);
                     state_in      = blf_pkg::ST_WALK;
                  end
               endcase
            end
         end
         blf_pkg::ST_WALK: begin
            if (fill_ff) begin
               wr_addr = fill_k_ff[ABITS-1:0];
               if (fill_k_ff >= (ABITS+1)'(fill_total_ff)) begin
                  state_in = blf_pkg::ST_DONE;
               end else begin
                  wr_en     = 1'b1;
                  n_in      = n_inc;
                  fill_k_in = fill_k_ff + (ABITS+1)'(1);
               end
            end else begin
               wr_en = inside_px;
               if (inside_px) begin
                  n_in = n_inc;
               end
               if (e_ff >= 0) begin
                  if (steep_ff) x_in = x_ff + EBITS'(sx_ff);
                  else          y_in = y_ff + EBITS'(sy_ff);
                  e_in = e_ff - two_major_ff + two_minor_ff;
               end else begin
                  e_in = e_ff + two_minor_ff;
               end
               if (steep_ff) y_in = y_ff + EBITS'(sy_ff);
               else          x_in = x_ff + EBITS'(sx_ff);
               left_in = left_ff - EBITS'(1);
               if (left_ff == EBITS'(1)) begin
                  state_in = blf_pkg::ST_DONE;
               end
            end
         end
         blf_pkg::ST_READ_WAIT: begin
            state_in = blf_pkg::ST_READ_DATA;
         end
         blf_pkg::ST_READ_DATA: begin
            rd_color_in = ins_ff ? rd_data : '0;
            state_in    = blf_pkg::ST_DONE;
         end
         blf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = rd_color_ff;
               rsp_n_in     = n_ff;
               rsp_ins_in   = ins_ff;
               state_in     = blf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = blf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blf_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      e_ff          <= e_in;
      two_major_ff  <= two_major_in;
      two_minor_ff  <= two_minor_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      steep_ff      <= steep_in;
      left_ff       <= left_in;
      fill_ff       <= fill_in;
      fill_k_ff     <= fill_k_in;
      fill_total_ff <= fill_total_in;
      color_ff      <= color_in;
      n_ff          <= n_in;
      rd_color_ff   <= rd_color_in;
      ins_ff        <= ins_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_n_ff      <= rsp_n_in;
      rsp_ins_ff    <= rsp_ins_in;
      rd_addr_ff    <= rd_addr_in;
   end

   assign busy               = (state_ff != blf_pkg::ST_IDLE) || q_valid;
   assign rsp_empty          = !rsp_valid_ff;
   assign rsp_read_color     = rsp_color_ff;
   assign rsp_pixels_written = rsp_n_ff;
   assign rsp_inside_res     = rsp_ins_ff;

endmodule

// ===== design/bresenham_line_framebuffer.sv =====
// channel  dir  handshake        payload
// req      in   req_push/full    command, x/y start, x/y end, pen_color
// rsp      out  empty/rsp_pop    read_color, pixels_written, inside_res
// csr      in   valid/ready      index, data (width, height)
//
// A line walks its major axis (zero length plots its start), a fill covers
// width*height, a plot writes one pixel, a read passes through ST_READ_WAIT
// and ST_READ_DATA. One pixel write per cycle. The MAX_WIDTH*MAX_HEIGHT
// store is cleared after reset; commands queue (two deep) but wait for it.
// The back end waits for the result register to drain before finishing.
// csr_ready is low during the clear and while a command is queued or running.
module bresenham_line_framebuffer #(
   parameter int unsigned MAX_WIDTH  = 128,
   parameter int unsigned MAX_HEIGHT = 128,
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [1:0]                     req_command,
   input  logic signed [COORD_BITS-1:0]   req_x_start,
   input  logic signed [COORD_BITS-1:0]   req_y_start,
   input  logic signed [COORD_BITS-1:0]   req_x_end,
   input  logic signed [COORD_BITS-1:0]   req_y_end,
   input  logic [31:0]                    req_pen_color,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [31:0]                    rsp_read_color,
   output logic [14:0]                    rsp_pixels_written,
   output logic                           rsp_inside_res,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [7:0]                     csr_data
);

   logic [7:0] width_ff, height_ff;
   logic       busy;
   logic       q_valid, q_pop;
   logic [1:0] q_command;
   logic signed [COORD_BITS-1:0] q_x_start, q_y_start, q_x_end, q_y_end;
   logic [31:0] q_pen_color;

   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd128;
         height_ff <= 8'd128;
      end else if (csr_valid && csr_ready) begin
         case (blf_pkg::csr_index_type'(csr_index))
            blf_pkg::CSR_WIDTH:  width_ff  <= csr_data;
            blf_pkg::CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   blf_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .req_push, .req_full, .req_command,
      .req_x_start, .req_y_start, .req_x_end, .req_y_end, .req_pen_color,
      .q_valid, .q_pop, .q_command, .q_x_start, .q_y_start,
      .q_x_end, .q_y_end, .q_pen_color
   );

   blf_back #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock, .reset, .width(width_ff), .height(height_ff), .busy,
      .q_valid, .q_pop, .q_command, .q_x_start, .q_y_start,
      .q_x_end, .q_y_end, .q_pen_color,
      .rsp_empty, .rsp_pop, .rsp_read_color, .rsp_pixels_written,
      .rsp_inside_res
   );

endmodule
